// ===== hw/rtl/tbrc_pkg.sv =====
package tbrc_pkg;

    localparam int unsigned LABEL_LEN = 9;

    typedef logic [7:0]  byte_t;
    typedef logic [3:0]  label_pos_t;
    typedef logic [11:0] length_t;
    typedef logic [4:0]  max_fields_t;
    typedef logic [5:0]  field_count_t;
    typedef logic [31:0] counter_t;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // register indexes on the write port
    localparam logic CFG_MAX_BLOCK_LENGTH = 1'b0;
    localparam logic CFG_MAX_FIELDS       = 1'b1;

    localparam length_t     MAX_BLOCK_LENGTH_RESET = 12'd512;
    localparam max_fields_t MAX_FIELDS_RESET       = 5'd22;

    localparam byte_t        CHAR_LF          = 8'h0A;
    localparam byte_t        CHAR_CR          = 8'h0D;
    localparam byte_t        CRLF_SUM         = 8'h17;
    localparam field_count_t FIELD_COUNT_MAX  = 6'd63;
    localparam label_pos_t   LABEL_LAST       = 4'd8;

    typedef struct packed {
        status_t      status;
        field_count_t fields;
        counter_t     blocks;
        counter_t     errors;
    } result_t;

    // "Checksum" followed by a tab
    function automatic byte_t label_char(input label_pos_t pos);
        byte_t c;
        case (pos)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h68;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h63;
            4'd4:    c = 8'h6B;
            4'd5:    c = 8'h73;
            4'd6:    c = 8'h75;
            4'd7:    c = 8'h6D;
            4'd8:    c = 8'h09;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/tbrc_core.sv =====
module tbrc_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  tbrc_pkg::byte_t        rx_byte,
    input  tbrc_pkg::length_t      max_block_length,
    input  tbrc_pkg::max_fields_t  max_fields,
    output logic                   res_valid,
    output tbrc_pkg::result_t      res
);
    import tbrc_pkg::*;

    label_pos_t   label_pos_reg, label_pos_next;
    logic         awaiting_reg, awaiting_next;
    length_t      byte_count_reg, byte_count_next;
    field_count_t field_count_reg, field_count_next;
    logic         sum_started_reg, sum_started_next;
    logic         prev_cr_reg, prev_cr_next;
    byte_t        sum_reg, sum_next;
    counter_t     good_reg, good_next;
    counter_t     error_reg, error_next;

    logic         was_first;
    logic         too_long;
    field_count_t fc_inc;
    logic         match_here;

    always_comb
    begin
        label_pos_next   = label_pos_reg;
        awaiting_next    = awaiting_reg;
        byte_count_next  = byte_count_reg;
        field_count_next = field_count_reg;
        sum_started_next = sum_started_reg;
        prev_cr_next     = prev_cr_reg;
        sum_next         = sum_reg;
        good_next        = good_reg;
        error_next       = error_reg;
        res_valid        = 1'b0;
        res.status       = STATUS_GOOD;
        res.fields       = field_count_reg;

        was_first = (byte_count_reg == '0);
        too_long  = (byte_count_reg >= max_block_length);
        fc_inc    = field_count_reg;
        if (rx_byte == CHAR_LF && field_count_reg < FIELD_COUNT_MAX)
        begin
            fc_inc = field_count_reg + 6'd1;
        end
        match_here = (rx_byte == label_char(label_pos_reg)) &&
                     (label_pos_reg != '0 || !was_first);

        if (too_long || fc_inc > {1'b0, max_fields})
        begin
            // drop the block
            res_valid        = 1'b1;
            res.status       = STATUS_OVERFLOW;
            res.fields       = fc_inc;
            error_next       = error_reg + 32'd1;
            label_pos_next   = '0;
            awaiting_next    = 1'b0;
            byte_count_next  = '0;
            field_count_next = '0;
            sum_started_next = 1'b0;
            prev_cr_next     = 1'b0;
            sum_next         = '0;
        end
        else
        begin
            field_count_next = fc_inc;
            byte_count_next  = byte_count_reg + 12'd1;
            if (sum_started_reg)
            begin
                sum_next = sum_reg + rx_byte;
            end
            else if (rx_byte == CHAR_LF && prev_cr_reg)
            begin
                sum_started_next = 1'b1;
                sum_next         = CRLF_SUM;
            end
            prev_cr_next = (rx_byte == CHAR_CR);

            if (awaiting_reg)
            begin
                res_valid  = 1'b1;
                res.fields = fc_inc;
                good_next  = good_reg + 32'd1;
                if (sum_started_next && sum_next == '0)
                begin
                    res.status = STATUS_GOOD;
                end
                else
                begin
                    res.status = STATUS_MISMATCH;
                    error_next = error_reg + 32'd1;
                end
                label_pos_next   = '0;
                awaiting_next    = 1'b0;
                byte_count_next  = '0;
                field_count_next = '0;
                sum_started_next = 1'b0;
                prev_cr_next     = 1'b0;
                sum_next         = '0;
            end
            else if (match_here)
            begin
                if (label_pos_reg == LABEL_LAST)
                begin
                    awaiting_next  = 1'b1;
                    label_pos_next = '0;
                end
                else
                begin
                    label_pos_next = label_pos_reg + 4'd1;
                end
            end
            else if (rx_byte == label_char('0) && !was_first)
            begin
                label_pos_next = 4'd1;
            end
            else
            begin
                label_pos_next = '0;
            end
        end
        res.blocks = good_next;
        res.errors = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_pos_reg   <= '0;
            awaiting_reg    <= 1'b0;
            byte_count_reg  <= '0;
            field_count_reg <= '0;
            sum_started_reg <= 1'b0;
            prev_cr_reg     <= 1'b0;
            sum_reg         <= '0;
            good_reg        <= '0;
            error_reg       <= '0;
        end
        else if (step)
        begin
            label_pos_reg   <= label_pos_next;
            awaiting_reg    <= awaiting_next;
            byte_count_reg  <= byte_count_next;
            field_count_reg <= field_count_next;
            sum_started_reg <= sum_started_next;
            prev_cr_reg     <= prev_cr_next;
            sum_reg         <= sum_next;
            good_reg        <= good_next;
            error_reg       <= error_next;
        end
    end

endmodule

// ===== hw/rtl/text_block_receiver_checksum.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  rx_byte (one received byte per request)
// output    out        out_valid/out_ready  block_status, block_fields,
//                                           blocks_received, errors_seen
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// One byte per cycle sustained while the result side is not stalled. A request
// is captured in the input register, then the framing logic updates the block
// state and, at a block end, loads the result register. Reset (asynchronous,
// active low) clears all block state and both counters and loads the register
// defaults. A stalled result holds the pipeline: the input register advances
// only while the result register is free or being taken.
module text_block_receiver_checksum (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  block_status,
    output logic [5:0]  block_fields,
    output logic [31:0] blocks_received,
    output logic [31:0] errors_seen,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);
    import tbrc_pkg::*;

    length_t     max_len_reg;
    max_fields_t max_fields_reg;

    logic        in_valid_reg;
    byte_t       in_byte_reg;
    logic        step;

    logic        res_valid;
    result_t     res;
    logic        out_valid_reg;
    result_t     out_reg;

    // configuration writes land directly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MAX_BLOCK_LENGTH_RESET;
            max_fields_reg <= MAX_FIELDS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_BLOCK_LENGTH: max_len_reg    <= cfg_data;
                CFG_MAX_FIELDS:       max_fields_reg <= cfg_data[4:0];
                default:              ;
            endcase
        end
    end

    // advance the held byte when the result side can take a block end
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    tbrc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .rx_byte          (in_byte_reg),
        .max_block_length (max_len_reg),
        .max_fields       (max_fields_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    // result register: load on a block end, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign block_status    = out_reg.status;
    assign block_fields    = out_reg.fields;
    assign blocks_received = out_reg.blocks;
    assign errors_seen     = out_reg.errors;

endmodule
